// ===== rtl/resp_stream_parser_assert.svh =====
// ----------------------------------------------------------------------------
// RESP stream parser assertion macros
// Shared property shapes for the checker. Each macro expects signals named
// clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef RESP_STREAM_PARSER_ASSERT_SVH
`define RESP_STREAM_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("resp_stream_parser: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("resp_stream_parser: assertion failed");

`endif

// ===== rtl/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser package
// Shared sizes, result codes and the structs passed between the parser blocks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsp_pkg;

	localparam int MAX_DEPTH = 8;
	localparam int SP_W      = $clog2(MAX_DEPTH + 1);
	localparam int CNT_W     = 32;
	localparam int ACC_W     = 64;
	localparam int DEPTH_W   = 4;

	localparam logic [1:0] EV_PAYLOAD = 2'd0;
	localparam logic [1:0] EV_HEADER  = 2'd1;
	localparam logic [1:0] EV_DONE    = 2'd2;
	localparam logic [1:0] EV_ERROR   = 2'd3;

	localparam logic [2:0] K_SIMPLE = 3'd0;
	localparam logic [2:0] K_ERROR  = 3'd1;
	localparam logic [2:0] K_INT    = 3'd2;
	localparam logic [2:0] K_BULK   = 3'd3;
	localparam logic [2:0] K_ARRAY  = 3'd4;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_TYPE     = 2'd1;
	localparam logic [1:0] ERR_DEPTH    = 2'd2;
	localparam logic [1:0] ERR_TOO_LONG = 2'd3;

	typedef struct packed {
		logic             clear;
		logic             push;
		logic             complete;
		logic [CNT_W-1:0] push_count;
	} stk_cmd_t;

	typedef struct packed {
		logic [SP_W-1:0] sp;
		logic            full;
		logic [SP_W-1:0] run;
		logic            empty_after;
	} stk_stat_t;

	typedef struct packed {
		logic [1:0]         event_res;
		logic [2:0]         kind;
		logic [7:0]         payload_byte;
		logic [ACC_W-1:0]   value;
		logic [DEPTH_W-1:0] depth;
		logic [DEPTH_W-1:0] arrays_closed;
		logic               message_done;
		logic [1:0]         error_code;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/rsp_in_reg.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser input register
// Holds one accepted stream byte until the parser logic consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_in_reg import rsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic [7:0] data_byte,
	output logic            byte_stall,
	input  wire logic       proc_en,
	output logic            valid_s1,
	output logic [7:0]      data_s1
);

	logic accept;

	assign byte_stall = valid_s1 && !proc_en;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= data_byte;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rsp_stack.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser array stack
// Remaining element counts of the open arrays. A completion pops every
// top entry that reaches zero and decrements the first one that survives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_stack import rsp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire stk_cmd_t  cmd,
	output stk_stat_t      stat
);

	logic [CNT_W-1:0]   cnt_q [MAX_DEPTH];
	logic [SP_W-1:0]    sp_q;
	logic [MAX_DEPTH:0] chain;
	logic [MAX_DEPTH-1:0] live;
	logic [MAX_DEPTH-1:0] popped;
	logic [MAX_DEPTH-1:0] dec_sel;
	logic [SP_W-1:0]    run;

	always_comb begin
		chain[MAX_DEPTH] = 1'b1;
		run = '0;
		for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
			live[i]    = SP_W'(i) < sp_q;
			chain[i]   = !live[i] || ((cnt_q[i] == CNT_W'(1)) && chain[i + 1]);
			popped[i]  = live[i] && chain[i];
			dec_sel[i] = live[i] && !chain[i] && chain[i + 1];
			run        = run + SP_W'(popped[i]);
		end
	end

	assign stat.sp          = sp_q;
	assign stat.full        = sp_q >= SP_W'(MAX_DEPTH);
	assign stat.run         = run;
	assign stat.empty_after = (sp_q == run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.clear) begin
			sp_q <= '0;
		end else if (cmd.push) begin
			sp_q <= sp_q + SP_W'(1);
		end else if (cmd.complete) begin
			sp_q <= sp_q - run;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_DEPTH; i++) begin
			if (cmd.push && (sp_q == SP_W'(i))) begin
				cnt_q[i] <= cmd.push_count;
			end else if (cmd.complete && dec_sel[i]) begin
				cnt_q[i] <= cnt_q[i] - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rsp_core.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser decode logic
// Phase tracking, number accumulation and result formation for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_core import rsp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       proc_en,
	input  wire logic [7:0] data_s1,
	input  wire stk_stat_t  stat,
	output stk_cmd_t        cmd,
	output logic            res_vld,
	output res_t            res
);

	localparam logic [2:0] PH_TYPE      = 3'd0;
	localparam logic [2:0] PH_SIMPLE    = 3'd1;
	localparam logic [2:0] PH_INT_FIRST = 3'd2;
	localparam logic [2:0] PH_INT_REST  = 3'd3;
	localparam logic [2:0] PH_LEN       = 3'd4;
	localparam logic [2:0] PH_SKIP_HDR  = 3'd5;
	localparam logic [2:0] PH_BULK      = 3'd6;
	localparam logic [2:0] PH_SKIP      = 3'd7;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	logic [2:0]       phase_q, phase_d;
	logic [2:0]       kind_q, kind_d;
	logic [ACC_W-1:0] acc_q, acc_d;
	logic             neg_q, neg_d;
	logic [CNT_W-1:0] rem_q, rem_d;

	logic             digit;
	logic [ACC_W-1:0] acc_dig;
	logic             err;
	logic [1:0]       err_code;
	logic             cpl;
	logic             cpl_self;
	logic [ACC_W-1:0] cpl_val;
	stk_cmd_t         cmd_c;

	assign digit   = (data_s1 >= CH_ZERO) && (data_s1 <= CH_NINE);
	assign acc_dig = (acc_q << 3) + (acc_q << 1) + ACC_W'(data_s1) - ACC_W'(CH_ZERO);

	always_comb begin
		phase_d  = phase_q;
		kind_d   = kind_q;
		acc_d    = acc_q;
		neg_d    = neg_q;
		rem_d    = rem_q;
		cmd_c    = '0;
		res      = '0;
		res_vld  = 1'b0;
		err      = 1'b0;
		err_code = ERR_NONE;
		cpl      = 1'b0;
		cpl_self = 1'b0;
		cpl_val  = '0;

		unique case (phase_q)
			PH_TYPE: begin
				acc_d = '0;
				neg_d = 1'b0;
				unique case (data_s1)
					CH_PLUS: begin
						kind_d  = K_SIMPLE;
						phase_d = PH_SIMPLE;
					end
					CH_MINUS: begin
						kind_d  = K_ERROR;
						phase_d = PH_SIMPLE;
					end
					CH_COLON: begin
						kind_d  = K_INT;
						phase_d = PH_INT_FIRST;
					end
					CH_DOLLAR: begin
						kind_d  = K_BULK;
						phase_d = PH_LEN;
					end
					CH_STAR: begin
						kind_d  = K_ARRAY;
						phase_d = PH_LEN;
					end
					default: begin
						err      = 1'b1;
						err_code = ERR_TYPE;
					end
				endcase
			end
			PH_SIMPLE: begin
				if (data_s1 == CH_CR) begin
					phase_d = PH_SKIP;
					cpl     = 1'b1;
				end else begin
					res_vld          = 1'b1;
					res.event_res    = EV_PAYLOAD;
					res.kind         = kind_q;
					res.payload_byte = data_s1;
					res.depth        = DEPTH_W'(stat.sp);
				end
			end
			PH_INT_FIRST, PH_INT_REST: begin
				if (data_s1 == CH_CR) begin
					phase_d = PH_SKIP;
					cpl     = 1'b1;
					cpl_val = neg_q ? (ACC_W'(0) - acc_q) : acc_q;
				end else begin
					if ((phase_q == PH_INT_FIRST) &&
					    ((data_s1 == CH_MINUS) || (data_s1 == CH_PLUS))) begin
						neg_d = (data_s1 == CH_MINUS);
					end else begin
						acc_d = acc_dig;
					end
					phase_d = PH_INT_REST;
				end
			end
			PH_LEN: begin
				if (digit) begin
					acc_d = acc_dig;
					if (acc_dig[ACC_W-1:CNT_W] != '0) begin
						err      = 1'b1;
						err_code = ERR_TOO_LONG;
					end
				end else begin
					phase_d       = PH_SKIP_HDR;
					res.event_res = EV_HEADER;
					res.kind      = kind_q;
					res.value     = acc_q;
					res.depth     = DEPTH_W'(stat.sp);
					res_vld       = 1'b1;
					if (kind_q == K_BULK) begin
						rem_d = acc_q[CNT_W-1:0];
					end else if (acc_q != '0) begin
						if (stat.full) begin
							err      = 1'b1;
							err_code = ERR_DEPTH;
						end else begin
							cmd_c.push       = 1'b1;
							cmd_c.push_count = acc_q[CNT_W-1:0];
						end
					end
				end
			end
			PH_SKIP_HDR: begin
				if (kind_q == K_BULK) begin
					phase_d = PH_BULK;
				end else begin
					phase_d = PH_TYPE;
					if (acc_q == '0) begin
						cpl      = 1'b1;
						cpl_self = 1'b1;
					end
				end
			end
			PH_BULK: begin
				if (rem_q != '0) begin
					rem_d            = rem_q - CNT_W'(1);
					res_vld          = 1'b1;
					res.event_res    = EV_PAYLOAD;
					res.kind         = K_BULK;
					res.payload_byte = data_s1;
					res.depth        = DEPTH_W'(stat.sp);
				end else begin
					phase_d = PH_SKIP;
					cpl     = 1'b1;
				end
			end
			PH_SKIP: begin
				phase_d = PH_TYPE;
			end
		endcase

		if (cpl) begin
			res_vld            = 1'b1;
			res.event_res      = EV_DONE;
			res.kind           = kind_q;
			res.value          = cpl_val;
			res.depth          = DEPTH_W'(stat.sp);
			res.arrays_closed  = DEPTH_W'(stat.run) + DEPTH_W'(cpl_self);
			res.message_done   = stat.empty_after;
			cmd_c.complete     = 1'b1;
		end

		if (err) begin
			res            = '0;
			res.event_res  = EV_ERROR;
			res.error_code = err_code;
			res_vld        = 1'b1;
			cmd_c          = '0;
			cmd_c.clear    = 1'b1;
			phase_d        = PH_TYPE;
			kind_d         = K_SIMPLE;
			acc_d          = '0;
			neg_d          = 1'b0;
			rem_d          = '0;
		end
	end

	assign cmd = proc_en ? cmd_c : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			kind_q  <= K_SIMPLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
		end else if (proc_en) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			rem_q   <= rem_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsp_out_reg import rsp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic proc_en,
	input  wire logic res_vld,
	input  wire res_t res,
	input  wire logic res_stall,
	output logic      res_valid,
	output res_t      res_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (proc_en) begin
			res_valid <= res_vld;
		end else if (!res_stall) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && res_vld) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/resp_stream_parser.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser
// Parses a RESP2 byte stream into payload, header, completion and error items.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (byte_valid, byte_stall, data_byte) takes one stream byte
// per item. The result channel (res_valid, res_stall and the result fields)
// gives at most one item per input byte; bytes such as type bytes, digits
// and line ends often give none.
// A byte is held in an input register, decoded against the parser state
// and written to the result register, which drives the result ports.
// One byte is taken every cycle
// while the receiver keeps up; the rate is set by the single decode stage
// that updates phase, accumulator and array stack together.
// When the receiver stalls with a result waiting, decoding halts only once
// the input register holds a byte, and then byte_stall rises.
// Reset empties both registers, returns the phase to expecting a type byte
// and the array stack to empty. An error item also returns the parser to that state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module resp_stream_parser import rsp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [1:0]       event_res,
	output logic [2:0]       kind,
	output logic [7:0]       payload_byte,
	output logic signed [63:0] value,
	output logic [3:0]       depth,
	output logic [3:0]       arrays_closed,
	output logic             message_done,
	output logic [1:0]       error_code
);

	logic      valid_s1;
	logic [7:0] data_s1;
	logic      proc_en;
	logic      res_vld;
	res_t      res;
	res_t      res_q;
	stk_cmd_t  stk_cmd;
	stk_stat_t stk_stat;

	assign proc_en = valid_s1 && (!res_valid || !res_stall);

	rsp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.data_byte  (data_byte),
		.byte_stall (byte_stall),
		.proc_en    (proc_en),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	rsp_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (stk_cmd),
		.stat   (stk_stat)
	);

	rsp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc_en (proc_en),
		.data_s1 (data_s1),
		.stat    (stk_stat),
		.cmd     (stk_cmd),
		.res_vld (res_vld),
		.res     (res)
	);

	rsp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.proc_en   (proc_en),
		.res_vld   (res_vld),
		.res       (res),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res_q     (res_q)
	);

	assign event_res     = res_q.event_res;
	assign kind          = res_q.kind;
	assign payload_byte  = res_q.payload_byte;
	assign value         = res_q.value;
	assign depth         = res_q.depth;
	assign arrays_closed = res_q.arrays_closed;
	assign message_done  = res_q.message_done;
	assign error_code    = res_q.error_code;

endmodule

`default_nettype wire

// ===== rtl/rsp_checker.sv =====
// ----------------------------------------------------------------------------
// RESP stream parser port checker
// Checks result items on the top-level ports and is bound to the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "resp_stream_parser_assert.svh"

module rsp_checker import rsp_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire logic [1:0]        event_res,
	input wire logic [2:0]        kind,
	input wire logic [7:0]        payload_byte,
	input wire logic signed [63:0] value,
	input wire logic [3:0]        depth,
	input wire logic              message_done,
	input wire logic [1:0]        error_code
);

	// An error item carries only its code.
	`RSP_ASSERT_NOW(a_err_clean, res_valid && (event_res == EV_ERROR), (error_code != ERR_NONE) && (kind == K_SIMPLE) && (depth == '0) && (value == '0))

	// Every other item reports no error.
	`RSP_ASSERT_NOW(a_no_err_code, res_valid && (event_res != EV_ERROR), error_code == ERR_NONE)

	// Only a completion may end a message.
	`RSP_ASSERT_NOW(a_done_on_cpl, res_valid && message_done, event_res == EV_DONE)

	// The payload byte is zero outside payload items.
	`RSP_ASSERT_NOW(a_payload_zero, res_valid && (event_res != EV_PAYLOAD), payload_byte == 8'd0)

	// A stalled item stays in place.
	`RSP_ASSERT_NEXT(a_stall_hold, res_valid && res_stall, res_valid && $stable(event_res) && $stable(value))

endmodule

bind resp_stream_parser rsp_checker u_rsp_checker (.*);

`default_nettype wire
